### hw/rtl/text_console_cursor_core_defines.svh
// Assertion macros shared by the text console cursor RTL.
`ifndef TEXT_CONSOLE_CURSOR_CORE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCC_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCC_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/tcc_pkg.sv
// Types, constants and tables for the text console cursor block.
package tcc_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned COORD_W = 8;
  localparam int unsigned COLOR_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Tab stop spacing in character cells (2..16).
  localparam int unsigned TAB_WIDTH = 8;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  localparam logic [COORD_W-1:0] COLUMNS_RST  = 8'd180;
  localparam logic [COORD_W-1:0] ROWS_RST     = 8'd56;
  localparam logic [COLOR_W-1:0] FG_COLOR_RST = '0;
  localparam logic [COLOR_W-1:0] BG_COLOR_RST = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMNS  = 2'd0,
    CFG_ROWS     = 2'd1,
    CFG_FG_COLOR = 2'd2,
    CFG_BG_COLOR = 2'd3
  } cfg_reg_e;

  localparam int unsigned NUM_COLS = 1 << COORD_W;

  typedef logic [NUM_COLS-1:0] tab_stop_t;

  // Bit i is set when column i is a tab stop.
  function automatic tab_stop_t build_tab_stop();
    tab_stop_t stops;
    for (int i = 0; i < NUM_COLS; i++) begin
      stops[i] = ((i % TAB_WIDTH) == 0);
    end
    return stops;
  endfunction

  localparam tab_stop_t TAB_STOP = build_tab_stop();

endpackage

### hw/rtl/tcc_intf.sv
// Valid/ready channel interfaces of the text console cursor block.
interface tcc_char_if import tcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface tcc_draw_if import tcc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] cell_column;
  logic [COORD_W-1:0] cell_row;
  logic [CHAR_W-1:0]  glyph;
  logic [COLOR_W-1:0] fore;
  logic [COLOR_W-1:0] back;
  logic               last;

  modport source (output valid, output cell_column, output cell_row, output glyph,
                  output fore, output back, output last, input ready);
  modport sink   (input valid, input cell_column, input cell_row, input glyph,
                  input fore, input back, input last, output ready);
endinterface

interface tcc_cfg_if import tcc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/text_console_cursor_core.sv
// Text console cursor: turns a character stream into character-cell draw commands.
// Usage:
//   char_i  - one character byte per transfer. Newline moves the cursor to the
//             start of the next row, tab pads with spaces to the next tab stop or
//             line end, backspace steps back and blanks a cell, others are drawn.
//   draw_o  - one draw command per transfer (cell, glyph, colors); last marks
//             the final command caused by one character.
//   cfg_i   - register writes (columns, rows, fg_color, bg_color); always ready.
//             Write only while no character is in flight.
// Timing:
//   A character sits in the hold register, then its draw command lands in the
//   output register. Plain characters, backspaces and newlines go at one per
//   cycle while draw_o is not stalled. A tab likewise draws one space per cycle
//   (up to TAB_WIDTH) and holds char_i.
// Reset:
//   Cursor returns to column 0, row 0; registers take 180 columns, 56 rows and
//   zero colors; hold and output registers empty.
// Stall:
//   While draw_o is stalled the result stays put; one more character may wait
//   in the hold register, after which char_i.ready drops.
`include "text_console_cursor_core_defines.svh"

module text_console_cursor_core import tcc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcc_char_if.sink    char_i,
  tcc_draw_if.source  draw_o,
  tcc_cfg_if.sink     cfg_i
);

  // Configuration registers
  logic [COORD_W-1:0] cols_q, rows_q;
  logic [COLOR_W-1:0] fg_q, bg_q;

  // Cursor state
  logic [COORD_W-1:0] col_q, col_d;
  logic [COORD_W-1:0] row_q, row_d;

  // Hold register for the character being worked on
  logic              full_q, full_d;
  logic [CHAR_W-1:0] char_q;

  // Output register
  logic               out_valid_q, out_valid_d;
  logic [COORD_W-1:0] out_col_q, out_row_q;
  logic [CHAR_W-1:0]  out_glyph_q;
  logic               out_last_q;

  // Step logic
  logic               emit, step_done, wrap_en, advance, out_free, in_xfer;
  logic [CHAR_W-1:0]  glyph;
  logic [COORD_W:0]   col9, row9, ncol9, nrow9, wcol9, wrow9;
  logic [COORD_W-1:0] col_inc;

  assign col9     = {1'b0, col_q};
  assign row9     = {1'b0, row_q};
  assign col_inc  = col_q + 1'b1;
  assign out_free = !out_valid_q || draw_o.ready;

  always_comb begin
    emit      = 1'b0;
    step_done = 1'b1;
    wrap_en   = 1'b1;
    glyph     = char_q;
    ncol9     = col9;
    nrow9     = row9;
    case (char_q)
      CH_NEWLINE: begin
        nrow9 = row9 + 1'b1;
        ncol9 = '0;
      end
      CH_TAB: begin
        // No room left on the line: draw nothing, only wrap.
        if (col_q < cols_q) begin
          emit      = 1'b1;
          glyph     = CH_SPACE;
          ncol9     = col9 + 1'b1;
          step_done = TAB_STOP[col_inc] || (ncol9 >= {1'b0, cols_q});
          wrap_en   = step_done;
        end
      end
      CH_BACKSPACE: begin
        emit  = 1'b1;
        glyph = CH_SPACE;
        if (col_q == '0) begin
          // Back up to the end of the previous row, or the last row from the top.
          ncol9 = {1'b0, cols_q - 1'b1};
          nrow9 = (row_q == '0) ? {1'b0, rows_q - 1'b1} : row9 - 1'b1;
        end else begin
          ncol9 = col9 - 1'b1;
        end
      end
      default: begin
        emit  = 1'b1;
        ncol9 = col9 + 1'b1;
      end
    endcase
  end

  // Line and screen wrap after each character
  always_comb begin
    wcol9 = ncol9;
    wrow9 = nrow9;
    if (ncol9 >= {1'b0, cols_q}) begin
      wcol9 = '0;
      wrow9 = nrow9 + 1'b1;
    end
    if (wrow9 >= {1'b0, rows_q}) begin
      wrow9 = '0;
    end
  end

  // Step when a character is held and the output register can take its command.
  assign advance = full_q && (!emit || out_free);
  assign char_i.ready = !full_q || (advance && step_done);
  assign in_xfer = char_i.valid && char_i.ready;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (advance) begin
      col_d = wrap_en ? wcol9[COORD_W-1:0] : ncol9[COORD_W-1:0];
      row_d = wrap_en ? wrow9[COORD_W-1:0] : nrow9[COORD_W-1:0];
    end
  end

  always_comb begin
    full_d = full_q;
    if (in_xfer) begin
      full_d = 1'b1;
    end else if (advance && step_done) begin
      full_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && emit) begin
      out_valid_d = 1'b1;
    end else if (draw_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold register payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      char_q <= char_i.char_code;
    end
  end

  // Output register payload; the command is drawn at the updated cursor
  // for backspace and at the current cursor otherwise.
  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_glyph_q <= glyph;
      out_last_q  <= step_done;
      if (char_q == CH_BACKSPACE) begin
        out_col_q <= ncol9[COORD_W-1:0];
        out_row_q <= nrow9[COORD_W-1:0];
      end else begin
        out_col_q <= col_q;
        out_row_q <= row_q;
      end
    end
  end

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLUMNS_RST;
      rows_q <= ROWS_RST;
      fg_q   <= FG_COLOR_RST;
      bg_q   <= BG_COLOR_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_COLUMNS:  cols_q <= cfg_i.data[COORD_W-1:0];
        CFG_ROWS:     rows_q <= cfg_i.data[COORD_W-1:0];
        CFG_FG_COLOR: fg_q   <= cfg_i.data[COLOR_W-1:0];
        CFG_BG_COLOR: bg_q   <= cfg_i.data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  assign draw_o.valid       = out_valid_q;
  assign draw_o.cell_column = out_col_q;
  assign draw_o.cell_row    = out_row_q;
  assign draw_o.glyph       = out_glyph_q;
  assign draw_o.last        = out_last_q;
  // User must change colors only while idle (unenforced) so every command matches.
  assign draw_o.fore        = fg_q;
  assign draw_o.back        = bg_q;

  // A finished character leaves the hold register unless a new one arrives.
  `TCC_ASSERT_NEXT(a_item_retires, clk_i, rst_ni, advance && step_done && !in_xfer, !full_q, "hold register not freed after last step")
  // A tab in mid-run keeps its character in place.
  `TCC_ASSERT_NEXT(a_tab_holds, clk_i, rst_ni, advance && !step_done, full_q && $stable(char_q), "tab character lost mid-run")
  // Every finished character leaves the row on screen.
  `TCC_ASSERT_NEXT(a_row_in_range, clk_i, rst_ni, advance && step_done, (row_q < $past(rows_q)) || (row_q == '0), "cursor row beyond last row")
  // Each step that draws fills the output register.
  `TCC_ASSERT_NEXT(a_emit_valid, clk_i, rst_ni, advance && emit, out_valid_q, "draw command dropped")

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the text console cursor core: directed table, then random phases.
module testbench;
  import tcc_pkg::*;

  // One draw command as it leaves the block.
  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [CHAR_W-1:0]  glyph;
    logic [COLOR_W-1:0] fore;
    logic [COLOR_W-1:0] back;
    logic               last;
  } draw_cmd_t;

  typedef enum logic {STEP_CHAR, STEP_WRITE} step_kind_e;

  // One row of the directed table: either a character or a register write.
  // A typed row carries the single draw command it must produce.
  typedef struct packed {
    step_kind_e           kind;
    cfg_reg_e             target;
    logic [CFG_DATA_W-1:0] value;
    logic [CHAR_W-1:0]    code;
    logic                 typed;
    draw_cmd_t            want;
  } script_step_t;

  localparam logic [COLOR_W-1:0] ONES = 32'hFFFF_FFFF;
  localparam draw_cmd_t NO_DRAW = '0;
  localparam int unsigned SCRIPT_LEN = 30;
  localparam int unsigned PHASES = 7;
  localparam int unsigned PHASE_ITEMS = 60;
  // Hold register plus output register, with margin.
  localparam int unsigned SETTLE_CYCLES = 4;

  // Walk from reset: plain extremes, tabs mid-line and at a stop, backspace across a
  // row start, then zero-sized screens, then a screen shrunk below the cursor.
  localparam script_step_t SCRIPT [SCRIPT_LEN] = '{
    '{STEP_CHAR,  CFG_COLUMNS, 32'h0, 8'h41, 1'b1, '{8'd0, 8'd0, 8'h41, 32'h0, 32'h0, 1'b1}},
    '{STEP_CHAR,  CFG_COLUMNS, 32'h0, 8'h00, 1'b1, '{8'd1, 8'd0, 8'h00, 32'h0, 32'h0, 1'b1}},
    '{STEP_CHAR,  CFG_COLUMNS, 32'h0, 8'hFF, 1'b1, '{8'd2, 8'd0, 8'hFF, 32'h0, 32'h0, 1'b1}},
    '{STEP_CHAR,  CFG_COLUMNS, 32'h0, CH_TAB, 1'b0, NO_DRAW},
    '{STEP_CHAR,  CFG_COLUMNS, 32'h0, CH_TAB, 1'b0, NO_DRAW},
    '{STEP_CHAR,  CFG_COLUMNS, 32'h0, CH_BACKSPACE, 1'b1,
      '{8'd15, 8'd0, CH_SPACE, 32'h0, 32'h0, 1'b1}},
    '{STEP_CHAR,  CFG_COLUMNS, 32'h0, CH_NEWLINE, 1'b0, NO_DRAW},
    '{STEP_CHAR,  CFG_COLUMNS, 32'h0, CH_BACKSPACE, 1'b1,
      '{8'd179, 8'd0, CH_SPACE, 32'h0, 32'h0, 1'b1}},
    '{STEP_WRITE, CFG_ROWS,     32'd2, 8'h00, 1'b0, NO_DRAW},
    '{STEP_WRITE, CFG_FG_COLOR, ONES,  8'h00, 1'b0, NO_DRAW},
    '{STEP_WRITE, CFG_BG_COLOR, 32'h0, 8'h00, 1'b0, NO_DRAW},
    '{STEP_CHAR,  CFG_COLUMNS, 32'h0, 8'h78, 1'b1, '{8'd179, 8'd0, 8'h78, ONES, 32'h0, 1'b1}},
    '{STEP_CHAR,  CFG_COLUMNS, 32'h0, CH_NEWLINE, 1'b0, NO_DRAW},
    '{STEP_CHAR,  CFG_COLUMNS, 32'h0, CH_BACKSPACE, 1'b1,
      '{8'd179, 8'd1, CH_SPACE, ONES, 32'h0, 1'b1}},
    '{STEP_CHAR,  CFG_COLUMNS, 32'h0, CH_TAB, 1'b1, '{8'd179, 8'd1, CH_SPACE, ONES, 32'h0, 1'b1}},
    '{STEP_WRITE, CFG_COLUMNS,  32'd0, 8'h00, 1'b0, NO_DRAW},
    '{STEP_WRITE, CFG_ROWS,     32'd0, 8'h00, 1'b0, NO_DRAW},
    '{STEP_CHAR,  CFG_COLUMNS, 32'h0, 8'h61, 1'b1, '{8'd0, 8'd0, 8'h61, ONES, 32'h0, 1'b1}},
    '{STEP_CHAR,  CFG_COLUMNS, 32'h0, CH_BACKSPACE, 1'b1,
      '{8'd255, 8'd255, CH_SPACE, ONES, 32'h0, 1'b1}},
    '{STEP_CHAR,  CFG_COLUMNS, 32'h0, CH_TAB, 1'b0, NO_DRAW},
    '{STEP_CHAR,  CFG_COLUMNS, 32'h0, CH_NEWLINE, 1'b0, NO_DRAW},
    '{STEP_WRITE, CFG_COLUMNS,  32'd255, 8'h00, 1'b0, NO_DRAW},
    '{STEP_WRITE, CFG_ROWS,     32'd255, 8'h00, 1'b0, NO_DRAW},
    '{STEP_CHAR,  CFG_COLUMNS, 32'h0, 8'h5A, 1'b1, '{8'd0, 8'd0, 8'h5A, ONES, 32'h0, 1'b1}},
    '{STEP_CHAR,  CFG_COLUMNS, 32'h0, CH_TAB, 1'b0, NO_DRAW},
    '{STEP_WRITE, CFG_COLUMNS,  32'd4, 8'h00, 1'b0, NO_DRAW},
    '{STEP_CHAR,  CFG_COLUMNS, 32'h0, CH_TAB, 1'b0, NO_DRAW},
    '{STEP_CHAR,  CFG_COLUMNS, 32'h0, 8'h71, 1'b1, '{8'd0, 8'd1, 8'h71, ONES, 32'h0, 1'b1}},
    '{STEP_WRITE, CFG_ROWS,     32'd1, 8'h00, 1'b0, NO_DRAW},
    '{STEP_CHAR,  CFG_COLUMNS, 32'h0, 8'h72, 1'b1, '{8'd1, 8'd1, 8'h72, ONES, 32'h0, 1'b1}}
  };

  logic clk;
  logic rst_n;

  tcc_char_if char_if ();
  tcc_draw_if draw_if ();
  tcc_cfg_if  cfg_if ();

  text_console_cursor_core DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .char_i (char_if),
    .draw_o (draw_if),
    .cfg_i  (cfg_if)
  );

  // Shadow of the block: cursor and the four registers.
  int unsigned         cur_col;
  int unsigned         cur_row;
  logic [COORD_W-1:0]  screen_cols;
  logic [COORD_W-1:0]  screen_rows;
  logic [COLOR_W-1:0]  ink_color;
  logic [COLOR_W-1:0]  paper_color;

  draw_cmd_t   pending_draws [$];
  int unsigned error_count;
  bit          quiet_phase;   // no gaps on either side while set
  int unsigned hold_request;  // long stall of draw_o, picked up by the sink

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard limit on the run; several times the slowest legal run.
  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Queue the draw command for one cell at the current row.
  function automatic void push_draw(input int unsigned col, input logic [CHAR_W-1:0] glyph);
    draw_cmd_t cmd;
    cmd.column = 8'(col);
    cmd.row    = 8'(cur_row);
    cmd.glyph  = glyph;
    cmd.fore   = ink_color;
    cmd.back   = paper_color;
    cmd.last   = 1'b0;
    pending_draws.push_back(cmd);
  endfunction

  // Advance the shadow cursor by one character and queue the draws it causes.
  function automatic void predict_draws(input logic [CHAR_W-1:0] code);
    int unsigned col;
    int unsigned span;
    int unsigned first;
    first = pending_draws.size();
    col   = cur_col;  // may reach 256 for one step
    if (code == CH_NEWLINE) begin
      cur_row = (cur_row + 1) & 'h1FF;
      col     = 0;
    end else if (code == CH_TAB) begin
      // Pad to the next stop, but never past the line end.
      span = TAB_WIDTH - (col % TAB_WIDTH);
      while (span > 0 && col < screen_cols) begin
        push_draw(col, CH_SPACE);
        col++;
        span--;
      end
    end else if (code == CH_BACKSPACE) begin
      // From column zero step to the last column of the row above, wrapping to the
      // bottom row from the top; counts of zero wrap to 255.
      if (col == 0) begin
        col     = 8'(screen_cols - 8'd1);
        cur_row = (cur_row == 0) ? 8'(screen_rows - 8'd1) : cur_row - 1;
      end else begin
        col--;
      end
      push_draw(col, CH_SPACE);
    end else begin
      push_draw(col, code);
      col++;
    end
    if (col >= screen_cols) begin
      cur_row++;
      col = 0;
    end
    if (cur_row >= screen_rows) begin
      cur_row = 0;
    end
    cur_col = col & 'hFF;
    cur_row = cur_row & 'hFF;
    if (pending_draws.size() > first) begin
      pending_draws[pending_draws.size()-1].last = 1'b1;
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: draw %s mismatch, expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Wait until every expected draw has arrived and the hold register has settled.
  task automatic drain_draws();
    char_if.valid = 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Write one register; call from a falling edge while the block is idle.
  task automatic cfg_write(input cfg_reg_e target, input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid = 1'b1;
    cfg_if.index = target;
    cfg_if.data  = value;
    do @(posedge clk); while (!cfg_if.ready);
    case (target)
      CFG_COLUMNS:  screen_cols = value[COORD_W-1:0];
      CFG_ROWS:     screen_rows = value[COORD_W-1:0];
      CFG_FG_COLOR: ink_color   = value;
      CFG_BG_COLOR: paper_color = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Offer one character after a random gap and hold it until the transfer.
  // Leaves valid high, so a back-to-back item keeps it up without a dip.
  task automatic send_char(input logic [CHAR_W-1:0] code, input logic typed,
                           input draw_cmd_t want, input bit no_gap);
    int unsigned gap;
    gap = (no_gap || quiet_phase) ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      char_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    char_if.valid     = 1'b1;
    char_if.char_code = code;
    do @(posedge clk); while (!char_if.ready);
    predict_draws(code);
    // A typed row replaces the predicted command with the one written in the table.
    if (typed) begin
      void'(pending_draws.pop_back());
      pending_draws.push_back(want);
    end
    @(negedge clk);
  endtask

  // Draw sink: drive ready at the falling edge, check each transfer at the rising edge.
  initial begin : draw_sink
    draw_cmd_t   got;
    draw_cmd_t   want;
    int unsigned gap_left;
    int unsigned hold_left;
    gap_left      = 0;
    hold_left     = 0;
    draw_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        draw_if.ready = 1'b0;
        hold_left--;
      end else if (gap_left != 0) begin
        draw_if.ready = 1'b0;
        gap_left--;
      end else begin
        draw_if.ready = 1'b1;
      end
      @(posedge clk);
      if (draw_if.valid && draw_if.ready) begin
        got = '{draw_if.cell_column, draw_if.cell_row, draw_if.glyph,
                draw_if.fore, draw_if.back, draw_if.last};
        if (pending_draws.size() == 0) begin
          $display("%0t: unexpected draw, expected none, got %h", $time, got);
          error_count++;
        end else begin
          want = pending_draws.pop_front();
          check_field("cell_column", want.column, got.column);
          check_field("cell_row",    want.row,    got.row);
          check_field("glyph",       want.glyph,  got.glyph);
          check_field("fore",        want.fore,   got.fore);
          check_field("back",        want.back,   got.back);
          check_field("last",        want.last,   got.last);
        end
        gap_left = quiet_phase ? 0 : $urandom_range(0, 10);
      end
    end
  end

  // Stimulus: reset, directed table, then random phases with fresh register settings.
  initial begin : stimulus
    logic [CHAR_W-1:0]    code;
    logic [COORD_W-1:0]   cols_set;
    logic [COORD_W-1:0]   rows_set;
    logic [COLOR_W-1:0]   fg_set;
    logic [COLOR_W-1:0]   bg_set;
    int unsigned          pick;
    int unsigned          burst_left;

    // Hold every input at a known value from time zero.
    rst_n             = 1'b0;
    char_if.valid     = 1'b0;
    char_if.char_code = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = CFG_COLUMNS;
    cfg_if.data       = '0;
    error_count       = 0;
    quiet_phase       = 1'b0;
    hold_request      = 0;
    cur_col           = 0;
    cur_row           = 0;
    screen_cols       = COLUMNS_RST;
    screen_rows       = ROWS_RST;
    ink_color         = FG_COLOR_RST;
    paper_color       = BG_COLOR_RST;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part: register rows wait for the block to go idle first.
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (SCRIPT[i].kind == STEP_WRITE) begin
        drain_draws();
        cfg_write(SCRIPT[i].target, SCRIPT[i].value);
      end else begin
        send_char(SCRIPT[i].code, SCRIPT[i].typed, SCRIPT[i].want, 1'b0);
      end
    end

    // Random part. Each phase starts from an idle block (the sender pauses until all
    // draws are in), rewrites every register, and keeps the cursor where it was, so a
    // smaller screen often leaves the cursor beyond its edge.
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_draws();
      case (phase)
        0:       begin cols_set = 8'd1;   rows_set = 8'd3;   end
        1:       begin cols_set = 8'd255; rows_set = 8'd255; end
        2:       begin cols_set = 8'd8;   rows_set = 8'd2;   end
        3:       begin cols_set = 8'($urandom_range(2, 40)); rows_set = 8'($urandom_range(1, 6)); end
        4:       begin cols_set = 8'd9;   rows_set = 8'd1;   end
        5:       begin cols_set = 8'($urandom_range(1, 255)); rows_set = 8'($urandom_range(1, 255)); end
        default: begin cols_set = 8'd17;  rows_set = 8'd4;   end
      endcase
      fg_set = (phase == 1) ? 32'h0 : $urandom;
      bg_set = (phase == 1) ? ONES  : $urandom;
      cfg_write(CFG_COLUMNS,  {24'h0, cols_set});
      cfg_write(CFG_ROWS,     {24'h0, rows_set});
      cfg_write(CFG_FG_COLOR, fg_set);
      cfg_write(CFG_BG_COLOR, bg_set);

      // Two phases run with no gaps at all on either side.
      quiet_phase = (phase == 3 || phase == 5);
      // In one phase, stall draw_o for a long stretch while characters keep coming
      // back to back, so the block fills up and drops char_i.ready.
      burst_left = 0;
      if (phase == 2) begin
        hold_request = 80;
        burst_left   = 30;
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Mostly plain bytes, with plenty of control characters.
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          code = CH_NEWLINE;
        end else if (pick < 27) begin
          code = CH_TAB;
        end else if (pick < 40) begin
          code = CH_BACKSPACE;
        end else begin
          code = 8'($urandom_range(0, 255));
        end
        send_char(code, 1'b0, NO_DRAW, burst_left != 0);
        if (burst_left != 0) burst_left--;
      end
    end

    // Drain, then allow a few more cycles for any stray draw to show up.
    drain_draws();
    quiet_phase = 1'b0;
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
